[design/mbfr_pkg.sv]
// shared types and constants of the msb-first bit field reader
package mbfr_pkg;

	localparam int STORE_BYTES_DEF    = 4096;
	localparam int MAX_FIELD_BITS_DEF = 32;

	localparam int BYTE_W    = 8;
	localparam int LOAD_AW   = 12;
	localparam int POS_W     = 15;
	localparam int WIDTH_W   = 6;
	localparam int FIELD_W   = 32;

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_READ = 1'b1;

	typedef struct packed {
		logic               req_type;
		logic [LOAD_AW-1:0] load_address;
		logic [BYTE_W-1:0]  load_byte;
		logic [POS_W-1:0]   begin_position;
		logic [WIDTH_W-1:0] field_width;
		logic               from_cursor;
	} req_t;

	typedef struct packed {
		logic [FIELD_W-1:0] field_bits;
		logic [POS_W-1:0]   next_position;
		logic               width_error;
	} rsp_t;

endpackage

[design/mbfr_ram.sv]
// generic simple dual-port ram, one write port, one registered read port
module mbfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[design/msb_first_bit_field_reader.sv]
// top level of the msb-first bit field reader: byte store, cursor and read sequencer
//
// a request is taken at a rising edge with start high and busy low. a load request
// writes one byte into the byte store in that same edge and produces no result; the
// next request can follow in the next cycle. a read request extracts a field of up to
// MAX_FIELD_BITS bits, msb first (bit 0 is the top bit of byte 0), starting at
// begin_position or at the stored cursor, and moves the cursor to start plus width,
// wrapping at the store size in bits. the byte store is a single ram with one read
// port and a registered read, so a read fetches one byte per cycle: a read that
// fetches its bytes (at most 5 for a 32-bit field; a zero-width read that starts
// inside a byte still fetches that one byte) keeps busy high through the fetch
// state and the drain state, and takes no new request until busy falls. a width
// above MAX_FIELD_BITS skips the fetch, returns all ones with width_error set, and
// still advances the cursor. the result is shown on rsp for exactly one cycle with
// done high, as busy falls low; there is no way to hold it off, so the
// receiver must take it then. STORE_BYTES must be a power of two; byte addresses
// and bit positions wrap modulo the store size. reading a byte never loaded gives
// an unspecified value. the cursor resets to zero; the store has no reset.
module msb_first_bit_field_reader #(
	parameter int STORE_BYTES    = mbfr_pkg::STORE_BYTES_DEF,
	parameter int MAX_FIELD_BITS = mbfr_pkg::MAX_FIELD_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  mbfr_pkg::req_t req,
	output logic           done,
	output mbfr_pkg::rsp_t rsp
);

	import mbfr_pkg::*;

	// ram address width and bit position width of the whole store
	localparam int AW = $clog2(STORE_BYTES);
	localparam int PW = AW + 3;
	// worst-case bytes a field touches, and the byte accumulator
	localparam int MB    = (MAX_FIELD_BITS + 14) / 8;
	localparam int ACC_W = BYTE_W * MB;
	localparam int CW    = $clog2(MB + 1);
	// positions wrap at the store size in bits, but never beyond 15 bits
	localparam logic [POS_W-1:0] POS_MASK =
		(PW >= POS_W) ? {POS_W{1'b1}} : POS_W'((32'd1 << PW) - 32'd1);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_FETCH = 3'b010,
		ST_DRAIN = 3'b100
	} state_t;

	state_t state_q;
	logic [POS_W-1:0] cursor_q;
	logic [CW-1:0]    cnt_q;
	logic             pend_q;
	logic             done_q;

	// per-read working registers
	logic [AW-1:0]      ptr_q;
	logic [ACC_W-1:0]   acc_q;
	logic [2:0]         drop_q;
	logic [WIDTH_W-1:0] width_q;
	logic               err_q;
	logic [POS_W-1:0]   next_q;
	rsp_t               rsp_q;

	logic accept, load_acc, read_acc;
	logic [POS_W-1:0]     start_pos;
	logic [POS_W:0]       pos_sum;
	logic [POS_W-1:0]     next_pos;
	logic                 width_err;
	logic [6:0]           span;
	logic [2:0]           tail;
	logic [CW-1:0]        nbytes;
	logic [AW+LOAD_AW-1:0] load_ext;
	logic [AW+LOAD_AW-1:0] byte_ext;
	logic [AW-1:0]        waddr, raddr;
	logic [BYTE_W-1:0]    rdata;
	logic [ACC_W-1:0]     acc_next;
	logic [ACC_W+FIELD_W-1:0] shifted;
	logic [FIELD_W:0]     wmask;
	logic [FIELD_W-1:0]   field;

	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && !busy;
	assign load_acc = accept && (req.req_type == REQ_LOAD);
	assign read_acc = accept && (req.req_type == REQ_READ);

	// start position, next position and error check
	assign start_pos = (req.from_cursor ? cursor_q : req.begin_position) & POS_MASK;
	assign pos_sum   = (POS_W+1)'(start_pos) + (POS_W+1)'(req.field_width);
	assign next_pos  = pos_sum[POS_W-1:0] & POS_MASK;
	assign width_err = req.field_width > WIDTH_W'(MAX_FIELD_BITS);

	// bytes spanned and low bits to drop after the last byte
	assign span   = 7'(start_pos[2:0]) + 7'(req.field_width) + 7'd7;
	assign nbytes = CW'(span[6:3]);
	assign tail   = start_pos[2:0] + req.field_width[2:0];

	// byte addresses wrap modulo the store size
	assign load_ext = {{AW{1'b0}}, req.load_address};
	assign byte_ext = {{AW{1'b0}}, start_pos[POS_W-1:3]};
	assign waddr    = load_ext[AW-1:0];
	assign raddr    = ptr_q;

	mbfr_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(STORE_BYTES)
	) u_store (
		.clk  (clk),
		.we   (load_acc),
		.waddr(waddr),
		.wdata(req.load_byte),
		.raddr(raddr),
		.rdata(rdata)
	);

	// the last byte arrives in the drain cycle; shift, then mask to the width
	assign acc_next = {acc_q[ACC_W-BYTE_W-1:0], rdata};
	assign shifted  = {{FIELD_W{1'b0}}, acc_next} >> drop_q;
	assign wmask    = ({{FIELD_W{1'b0}}, 1'b1} << width_q) - {{FIELD_W{1'b0}}, 1'b1};
	assign field    = shifted[FIELD_W-1:0] & wmask[FIELD_W-1:0];

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cursor_q <= '0;
			cnt_q    <= '0;
			pend_q   <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			pend_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (read_acc) begin
						cursor_q <= next_pos;
						cnt_q    <= nbytes;
						if (width_err || (nbytes == '0)) begin
							state_q <= ST_DRAIN;
						end else begin
							state_q <= ST_FETCH;
						end
					end
				end
				ST_FETCH: begin
					pend_q <= 1'b1;
					cnt_q  <= cnt_q - CW'(1);
					if (cnt_q == CW'(1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (read_acc) begin
			ptr_q   <= byte_ext[AW-1:0];
			drop_q  <= 3'd0 - tail;
			width_q <= req.field_width;
			err_q   <= width_err;
			next_q  <= next_pos;
		end
		if (state_q == ST_FETCH) begin
			ptr_q <= ptr_q + AW'(1);
		end
		if (pend_q) begin
			acc_q <= acc_next;
		end
		if (state_q == ST_DRAIN) begin
			rsp_q.field_bits    <= err_q ? {FIELD_W{1'b1}} : field;
			rsp_q.next_position <= next_q;
			rsp_q.width_error   <= err_q;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule
